// File: rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and codes for the matrix multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

  localparam int unsigned DimW  = 4;
  localparam int unsigned ProdW = 64;
  localparam int unsigned FuncW = 2;
  localparam int unsigned CfgW  = 2;

  localparam logic [FuncW-1:0] FuncLoadA   = 2'd0;
  localparam logic [FuncW-1:0] FuncLoadB   = 2'd1;
  localparam logic [FuncW-1:0] FuncCompute = 2'd2;

  localparam logic [CfgW-1:0] CfgRowsA = 2'd0;
  localparam logic [CfgW-1:0] CfgColsA = 2'd1;
  localparam logic [CfgW-1:0] CfgRowsB = 2'd2;
  localparam logic [CfgW-1:0] CfgColsB = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDrain,
    StOut
  } st_e;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mm_ram.sv
// ----------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mm_mac.sv
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit: registered signed product, then a
// saturating 64-bit accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_mac #(
  parameter int unsigned ValueWidth = 32
) (
  input  wire logic                         clk_i,
  input  wire mm_pkg::mac_ctrl_t            ctrl_i,
  input  wire logic signed [ValueWidth-1:0] a_i,
  input  wire logic signed [ValueWidth-1:0] b_i,
  output logic signed [mm_pkg::ProdW-1:0]   acc_o
);

  localparam int unsigned MulW = 2 * ValueWidth;

  logic signed [MulW-1:0]          mul;
  logic signed [mm_pkg::ProdW-1:0] prod_q;
  logic signed [mm_pkg::ProdW-1:0] acc_q, acc_d;
  logic        [mm_pkg::ProdW:0]   sum;

  assign mul = a_i * b_i;
  assign sum = {acc_q[mm_pkg::ProdW-1], acc_q} + {prod_q[mm_pkg::ProdW-1], prod_q};

  always_comb begin
    if (sum[mm_pkg::ProdW] != sum[mm_pkg::ProdW-1]) begin
      // overflow: clamp toward the sign of the true sum
      acc_d = sum[mm_pkg::ProdW] ? {1'b1, {(mm_pkg::ProdW-1){1'b0}}}
                                 : {1'b0, {(mm_pkg::ProdW-1){1'b1}}};
    end else begin
      acc_d = sum[mm_pkg::ProdW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mm_pkg::ProdW'(mul);
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// C = A * B over element stores loaded one at a time; C emitted row-major.
// ----------------------------------------------------------------------------
//   channel  signals                               direction
//   in       in_valid_i/in_ready_o, func..value    to block
//   out      out_valid_o/out_ready_i, out_row..    from block
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i       to block, write only
//
// Load transfers are accepted only while idle. A compute transfer
// produces the m * p results in turn: one multiply-accumulate unit
// walks the inner dimension, fed by one read port per element store.
// An error result skips the MAC pass. in_ready_o stays low until the last
// result transfers; a stalled result holds in its output register.
// Reset sets the dimension registers to 8; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply #(
  parameter int unsigned MAX_DIM     = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mm_pkg::CfgW-1:0]     cfg_idx_i,
  input  wire logic [mm_pkg::DimW-1:0]     cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mm_pkg::FuncW-1:0]    func_i,
  input  wire logic [2:0]                  row_i,
  input  wire logic [2:0]                  col_i,
  input  wire logic signed [31:0]          value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       out_row_o,
  output logic [2:0]                       out_col_o,
  output logic signed [mm_pkg::ProdW-1:0]  product_o,
  output logic                             last_o,
  output logic                             error_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [mm_pkg::DimW-1:0] DimMax = mm_pkg::DimW'(MAX_DIM);
  localparam logic [mm_pkg::DimW-1:0] DimOne = mm_pkg::DimW'(1);

  function automatic logic [mm_pkg::DimW-1:0] clamp_dim(input logic [mm_pkg::DimW-1:0] d);
    return (d > DimMax) ? DimMax : d;
  endfunction

  logic [mm_pkg::DimW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [mm_pkg::DimW-1:0] m, n, nb, p;

  mm_pkg::st_e       state_q, state_d;
  logic [IdxW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic              err_q, err_d;
  logic              rd_vld_q, mul_vld_q;
  logic              issue, bad_dims, last_elem;
  mm_pkg::mac_ctrl_t mac_ctrl;

  logic                          in_xfer, ld_ok, we_a, we_b;
  logic [AddrW-1:0]              waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0]        rdata_a, rdata_b;
  logic signed [mm_pkg::ProdW-1:0] acc;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mm_pkg::DimW'(8);
      cols_a_q <= mm_pkg::DimW'(8);
      rows_b_q <= mm_pkg::DimW'(8);
      cols_b_q <= mm_pkg::DimW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mm_pkg::CfgRowsA: rows_a_q <= cfg_data_i;
        mm_pkg::CfgColsA: cols_a_q <= cfg_data_i;
        mm_pkg::CfgRowsB: rows_b_q <= cfg_data_i;
        mm_pkg::CfgColsB: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign m  = clamp_dim(rows_a_q);
  assign n  = clamp_dim(cols_a_q);
  assign nb = clamp_dim(rows_b_q);
  assign p  = clamp_dim(cols_b_q);

  assign bad_dims = (m == '0) || (n == '0) || (nb == '0) || (p == '0) || (n != nb);

  // element loads
  assign in_xfer = in_valid_i && in_ready_o;
  assign ld_ok   = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign we_a    = in_xfer && ld_ok && (func_i == mm_pkg::FuncLoadA);
  assign we_b    = in_xfer && ld_ok && (func_i == mm_pkg::FuncLoadB);
  assign waddr   = AddrW'(32'(row_i) * MAX_DIM + 32'(col_i));
  assign raddr_a = AddrW'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign raddr_b = AddrW'(32'(k_q) * MAX_DIM + 32'(j_q));

  mm_ram #(.Width(VALUE_WIDTH), .Depth(Depth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (value_i[VALUE_WIDTH-1:0]),
    .re_i    (issue),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_ram #(.Width(VALUE_WIDTH), .Depth(Depth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (value_i[VALUE_WIDTH-1:0]),
    .re_i    (issue),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mm_mac #(.ValueWidth(VALUE_WIDTH)) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (acc)
  );

  assign last_elem = err_q ||
                     ((mm_pkg::DimW'(i_q) == m - DimOne) &&
                      (mm_pkg::DimW'(j_q) == p - DimOne));

  // sequencer
  always_comb begin
    state_d          = state_q;
    i_d              = i_q;
    j_d              = j_q;
    k_d              = k_q;
    err_d            = err_q;
    issue            = 1'b0;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    mac_ctrl.mul_en  = rd_vld_q;
    mac_ctrl.acc_en  = mul_vld_q;
    mac_ctrl.acc_clr = 1'b0;
    unique case (state_q)
      mm_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (func_i == mm_pkg::FuncCompute)) begin
          i_d              = '0;
          j_d              = '0;
          k_d              = '0;
          err_d            = bad_dims;
          mac_ctrl.acc_clr = 1'b1;
          state_d          = bad_dims ? mm_pkg::StOut : mm_pkg::StMac;
        end
      end
      mm_pkg::StMac: begin
        issue = 1'b1;
        if (mm_pkg::DimW'(k_q) == n - DimOne) begin
          k_d     = '0;
          state_d = mm_pkg::StDrain;
        end else begin
          k_d = IdxW'(k_q + 1'b1);
        end
      end
      mm_pkg::StDrain: begin
        if (!rd_vld_q && !mul_vld_q) begin
          state_d = mm_pkg::StOut;
        end
      end
      mm_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_elem) begin
            state_d = mm_pkg::StIdle;
          end else begin
            if (mm_pkg::DimW'(j_q) == p - DimOne) begin
              j_d = '0;
              i_d = IdxW'(i_q + 1'b1);
            end else begin
              j_d = IdxW'(j_q + 1'b1);
            end
            mac_ctrl.acc_clr = 1'b1;
            state_d          = mm_pkg::StMac;
          end
        end
      end
      default: state_d = mm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mm_pkg::StIdle;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      err_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      err_q     <= err_d;
      rd_vld_q  <= issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  assign out_row_o = 3'(i_q);
  assign out_col_o = 3'(j_q);
  assign product_o = acc;
  assign last_o    = last_elem;
  assign error_o   = err_q;

endmodule

`default_nettype wire
